### rtl/ofsb_pkg.sv
// Shared constants and command type for the overflow spill byte FIFO.
// No dependencies; imported by every module of the block except ofsb_ram.
`default_nettype none
package ofsb_pkg;

  // Store depths
  localparam int NORMAL_DEPTH = 1024;
  localparam int PEAK_DEPTH   = 4096;

  // Pointer and fill widths derived from the depths
  localparam int N_AW = $clog2(NORMAL_DEPTH);
  localparam int N_FW = $clog2(NORMAL_DEPTH + 1);
  localparam int P_AW = $clog2(PEAK_DEPTH);
  localparam int P_FW = $clog2(PEAK_DEPTH + 1);

  // Capacity register widths, fixed by the register map
  localparam int NCAP_W = 11;
  localparam int PCAP_W = 13;
  localparam int CFG_W  = 13;
  localparam int CFG_IDX_W = 2;

  // Common width for fill against capacity compares
  localparam int NCMP_W = (N_FW > NCAP_W) ? N_FW : NCAP_W;
  localparam int PCMP_W = (P_FW > PCAP_W) ? P_FW : PCAP_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_CAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_CAP   = 2'd1;

  // Capacity reset values
  localparam logic [NCAP_W-1:0] NORMAL_CAP_RESET = 11'd1024;
  localparam logic [PCAP_W-1:0] PEAK_CAP_RESET   = 13'd4096;

  // Request types
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;     // request accepted this cycle
    logic load_rd;  // read data is back, load the result register
  } ofsb_cmd_t;

endpackage
`default_nettype wire

### rtl/ofsb_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
`default_nettype none
module ofsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/ofsb_ctrl.sv
// Controller for the overflow spill byte FIFO: request handshake, read wait
// state and result valid. Depends on ofsb_pkg.
`default_nettype none
module ofsb_ctrl import ofsb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic req_type,
  output logic      out_valid,
  input  wire logic out_ready,
  output ofsb_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_RDATA
  } state_t;

  state_t state;

  // Take a request only when idle and the result slot is free this cycle
  assign in_ready    = (state == S_IDLE) && (!out_valid || out_ready);
  assign cmd.take    = in_valid && in_ready;
  assign cmd.load_rd = (state == S_RDATA);

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.take && (req_type == REQ_READ)) begin
            state <= S_RDATA;
            if (out_ready) begin
              out_valid <= 1'b0;
            end
          end else if (cmd.take) begin
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_RDATA: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/ofsb_dpath.sv
// Datapath for the overflow spill byte FIFO: capacities, ring pointers, the
// two byte stores and the result register. Depends on ofsb_pkg and ofsb_ram.
`default_nettype none
module ofsb_dpath import ofsb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ofsb_cmd_t            cmd,
  input  wire logic                 req_type,
  input  wire logic [7:0]           write_byte,
  input  wire logic                 chunk_end,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output logic                      accepted,
  output logic [7:0]                read_byte,
  output logic                      chunk_ok,
  output logic                      queue_empty,
  output logic                      spill_active
);

  logic [NCAP_W-1:0] normal_cap;
  logic [PCAP_W-1:0] peak_cap;
  logic [N_AW-1:0]   n_head, n_tail;
  logic [N_FW-1:0]   n_fill, n_fill_next;
  logic [P_AW-1:0]   p_head, p_tail;
  logic [P_FW-1:0]   p_fill, p_fill_next;
  logic              chunk_failed;

  logic              n_room, p_room, peak_busy;
  logic              to_normal, to_peak, push_ok;
  logic              pop_n, pop_p;
  logic              is_read, do_append, do_read;
  logic              rd_from_n, rd_from_p, pend_empty, pend_spill;
  logic [7:0]        n_rdata, p_rdata;

  assign is_read   = (req_type == REQ_READ);
  assign do_append = cmd.take && !is_read;
  assign do_read   = cmd.take && is_read;

  // Room checks; a capacity above the depth acts as the depth
  assign n_room = (NCMP_W'(n_fill) < NCMP_W'(normal_cap)) &&
                  (n_fill < N_FW'(NORMAL_DEPTH));
  assign p_room = (PCMP_W'(p_fill) < PCMP_W'(peak_cap)) &&
                  (p_fill < P_FW'(PEAK_DEPTH));

  // Append routing: stay in the peak store while it holds data
  assign peak_busy = (p_fill != '0);
  assign to_normal = !peak_busy && n_room;
  assign to_peak   = peak_busy ? p_room : (!n_room && p_room);
  assign push_ok   = to_normal || to_peak;

  // Read routing: normal store first
  assign pop_n = (n_fill != '0);
  assign pop_p = !pop_n && peak_busy;

  // Fill after this request
  always_comb begin
    n_fill_next = n_fill;
    p_fill_next = p_fill;
    if (is_read) begin
      n_fill_next = n_fill - N_FW'(pop_n);
      p_fill_next = p_fill - P_FW'(pop_p);
    end else begin
      n_fill_next = n_fill + N_FW'(to_normal);
      p_fill_next = p_fill + P_FW'(to_peak);
    end
  end

  // Capacity registers
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_cap <= NORMAL_CAP_RESET;
      peak_cap   <= PEAK_CAP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_NORMAL_CAP) begin
        normal_cap <= cfg_data[NCAP_W-1:0];
      end else if (cfg_index == REG_PEAK_CAP) begin
        peak_cap <= cfg_data[PCAP_W-1:0];
      end
    end
  end

  // Ring pointers, fills and chunk flag
  always_ff @(posedge clk) begin
    if (rst) begin
      n_head       <= '0;
      n_tail       <= '0;
      n_fill       <= '0;
      p_head       <= '0;
      p_tail       <= '0;
      p_fill       <= '0;
      chunk_failed <= 1'b0;
    end else if (cmd.take) begin
      n_fill <= n_fill_next;
      p_fill <= p_fill_next;
      if (do_append) begin
        if (to_normal) begin
          n_tail <= (n_tail == N_AW'(NORMAL_DEPTH - 1)) ? '0 : n_tail + N_AW'(1);
        end
        if (to_peak) begin
          p_tail <= (p_tail == P_AW'(PEAK_DEPTH - 1)) ? '0 : p_tail + P_AW'(1);
        end
        if (chunk_end) begin
          chunk_failed <= 1'b0;
        end else if (!push_ok) begin
          chunk_failed <= 1'b1;
        end
      end else begin
        if (pop_n) begin
          n_head <= (n_head == N_AW'(NORMAL_DEPTH - 1)) ? '0 : n_head + N_AW'(1);
        end
        if (pop_p) begin
          p_head <= (p_head == P_AW'(PEAK_DEPTH - 1)) ? '0 : p_head + P_AW'(1);
        end
      end
    end
  end

  // Byte stores; the read port always looks at the head
  ofsb_ram #(.WIDTH(8), .DEPTH(NORMAL_DEPTH)) u_normal_ram (
    .clk   (clk),
    .we    (do_append && to_normal),
    .waddr (n_tail),
    .wdata (write_byte),
    .raddr (n_head),
    .rdata (n_rdata)
  );

  ofsb_ram #(.WIDTH(8), .DEPTH(PEAK_DEPTH)) u_peak_ram (
    .clk   (clk),
    .we    (do_append && to_peak),
    .waddr (p_tail),
    .wdata (write_byte),
    .raddr (p_head),
    .rdata (p_rdata)
  );

  // Read bookkeeping held until the store data is back
  always_ff @(posedge clk) begin
    if (do_read) begin
      rd_from_n  <= pop_n;
      rd_from_p  <= pop_p;
      pend_empty <= (n_fill_next == '0) && (p_fill_next == '0);
      pend_spill <= (p_fill_next != '0);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (do_append) begin
      accepted     <= push_ok;
      read_byte    <= 8'd0;
      chunk_ok     <= chunk_end && !chunk_failed && push_ok;
      queue_empty  <= (n_fill_next == '0) && (p_fill_next == '0);
      spill_active <= (p_fill_next != '0);
    end else if (cmd.load_rd) begin
      accepted     <= rd_from_n || rd_from_p;
      read_byte    <= rd_from_n ? n_rdata : (rd_from_p ? p_rdata : 8'd0);
      chunk_ok     <= 1'b0;
      queue_empty  <= pend_empty;
      spill_active <= pend_spill;
    end
  end

endmodule
`default_nettype wire

### rtl/overflow_spill_byte_fifo.sv
// Byte queue with a normal FIFO and an overflow FIFO; top level.
// Appends: result the cycle after acceptance, one per cycle if out_ready is high.
// Reads: store read register, then result register; no request taken until loaded.
// Reset (synchronous, active high) clears pointers, fills, chunk flag and
// result valid, and sets capacities to 1024 and 4096; stores are not cleared.
// Depends on ofsb_pkg, ofsb_ctrl, ofsb_dpath and ofsb_ram.
`default_nettype none
module overflow_spill_byte_fifo import ofsb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 req_type,
  input  wire logic [7:0]           write_byte,
  input  wire logic                 chunk_end,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      accepted,
  output logic [7:0]                read_byte,
  output logic                      chunk_ok,
  output logic                      queue_empty,
  output logic                      spill_active,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  ofsb_cmd_t cmd;

  ofsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ofsb_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_type     (req_type),
    .write_byte   (write_byte),
    .chunk_end    (chunk_end),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accepted     (accepted),
    .read_byte    (read_byte),
    .chunk_ok     (chunk_ok),
    .queue_empty  (queue_empty),
    .spill_active (spill_active)
  );

`ifndef SYNTHESIS
  // Read data never lands on a result still waiting to be taken
  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_rd |-> !out_valid)
    else $error("read result loaded over a pending result");

  // A rejected request carries no byte
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |-> (read_byte == 8'd0))
    else $error("rejected request returned a byte");

  // A good chunk end means this byte was stored
  a_chunk_ok_stored: assert property (@(posedge clk) disable iff (rst)
    (out_valid && chunk_ok) |-> accepted)
    else $error("chunk reported good on a rejected byte");

  // Empty queue cannot have overflow data
  a_empty_no_spill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && queue_empty) |-> !spill_active)
    else $error("empty queue reports overflow data");
`endif

endmodule
`default_nettype wire

### tb/overflow_spill_byte_fifo_tb.sv
// Self-checking testbench for the overflow spill byte FIFO: directed and random
// requests against a built-in prediction of both FIFOs, the spill rule and the chunk flag.
// Depends on ofsb_pkg and the overflow_spill_byte_fifo RTL.
`default_nettype none
module overflow_spill_byte_fifo_tb;
  import ofsb_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } fifo_req_t;

  typedef struct packed {
    logic       acc;
    logic [7:0] rbyte;
    logic       cok;
    logic       empty;
    logic       spill;
  } fifo_resp_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 req_type = REQ_APPEND;
  logic [7:0]           write_byte = 8'd0;
  logic                 chunk_end = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic                 accepted;
  logic [7:0]           read_byte;
  logic                 chunk_ok;
  logic                 queue_empty;
  logic                 spill_active;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_NORMAL_CAP;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Request queue feeding the driver, and results still owed by the block
  fifo_req_t  pending_reqs[$];
  fifo_resp_t owed_results[$];
  int         sent_cnt = 0;
  int         taken_cnt = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         errors = 0;
  bit         steady = 1'b0;

  // Predicted contents of the two byte stores
  logic [7:0]        normal_mem [NORMAL_DEPTH];
  logic [7:0]        peak_mem [PEAK_DEPTH];
  int                normal_head = 0;
  int                normal_fill = 0;
  int                peak_head = 0;
  int                peak_fill = 0;
  bit                chunk_bad = 1'b0;
  logic [NCAP_W-1:0] norm_cap = NORMAL_CAP_RESET;
  logic [PCAP_W-1:0] peak_cap = PEAK_CAP_RESET;

  overflow_spill_byte_fifo dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .write_byte   (write_byte),
    .chunk_end    (chunk_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .read_byte    (read_byte),
    .chunk_ok     (chunk_ok),
    .queue_empty  (queue_empty),
    .spill_active (spill_active),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none in steady stretches
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady) return 0;
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Expected result of one request; updates the predicted state
  function automatic fifo_resp_t spill_fifo_step(fifo_req_t r);
    fifo_resp_t res;
    int         n_lim;
    int         p_lim;
    bit         to_peak;
    res     = '0;
    n_lim   = (norm_cap > NORMAL_DEPTH) ? NORMAL_DEPTH : int'(norm_cap);
    p_lim   = (peak_cap > PEAK_DEPTH) ? PEAK_DEPTH : int'(peak_cap);
    if (r.kind == REQ_APPEND) begin
      // peak FIFO takes everything while it holds data
      to_peak = (peak_fill > 0);
      if (!to_peak) begin
        if (normal_fill < n_lim) begin
          normal_mem[(normal_head + normal_fill) % NORMAL_DEPTH] = r.data;
          normal_fill++;
          res.acc = 1'b1;
        end else begin
          to_peak = 1'b1;
        end
      end
      if (to_peak && peak_fill < p_lim) begin
        peak_mem[(peak_head + peak_fill) % PEAK_DEPTH] = r.data;
        peak_fill++;
        res.acc = 1'b1;
      end
      if (!res.acc) chunk_bad = 1'b1;
      if (r.last) begin
        res.cok   = !chunk_bad;
        chunk_bad = 1'b0;
      end
    end else if (normal_fill > 0) begin
      res.rbyte   = normal_mem[normal_head];
      normal_head = (normal_head + 1) % NORMAL_DEPTH;
      normal_fill--;
      res.acc     = 1'b1;
    end else if (peak_fill > 0) begin
      res.rbyte = peak_mem[peak_head];
      peak_head = (peak_head + 1) % PEAK_DEPTH;
      peak_fill--;
      res.acc   = 1'b1;
    end
    res.empty = (normal_fill == 0 && peak_fill == 0);
    res.spill = (peak_fill > 0);
    return res;
  endfunction

  // Request driver: next request or a gap once the last one is taken
  always @(negedge clk) begin : req_driver
    fifo_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (taken_cnt == sent_cnt) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        req_type   <= nxt.kind;
        write_byte <= nxt.data;
        chunk_end  <= nxt.last;
        in_valid   <= 1'b1;
        sent_cnt   <= sent_cnt + 1;
        gap_left   <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin : result_stall
    if (rst) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk) begin : result_check
    fifo_resp_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        owed_results.push_back(spill_fifo_step({req_type, write_byte, chunk_end}));
        taken_cnt <= taken_cnt + 1;
      end
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = owed_results.pop_front();
          check_field("accepted", want.acc, accepted);
          check_field("read_byte", want.rbyte, read_byte);
          check_field("chunk_ok", want.cok, chunk_ok);
          check_field("queue_empty", want.empty, queue_empty);
          check_field("spill_active", want.spill, spill_active);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NORMAL_CAP) norm_cap = val[NCAP_W-1:0];
    else peak_cap = val[PCAP_W-1:0];
  endtask

  task automatic set_caps(int ncap, int pcap);
    write_reg(REG_NORMAL_CAP, CFG_W'(ncap));
    write_reg(REG_PEAK_CAP, CFG_W'(pcap));
  endtask

  task automatic push_req(logic kind, logic [7:0] data, logic last);
    pending_reqs.push_back('{kind: kind, data: data, last: last});
  endtask

  // Block until every request is taken and every result has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (!(pending_reqs.size() == 0 && taken_cnt == sent_cnt &&
             owed_results.size() == 0));
    repeat (4) @(negedge clk);
  endtask

  // Random requests under one capacity setting; stored data carries over
  task automatic run_phase(int ncap, int pcap, int count, int append_pct);
    set_caps(ncap, pcap);
    steady = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      push_req(($urandom_range(0, 99) < append_pct) ? REQ_APPEND : REQ_READ,
               8'($urandom), ($urandom_range(0, 4) == 0));
    end
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Spill, peak-first appends, rejection and chunk flag
    set_caps(2, 3);
    push_req(REQ_READ,   8'hFF, 1'b1);  // empty read, chunk end ignored
    push_req(REQ_APPEND, 8'h00, 1'b0);
    push_req(REQ_APPEND, 8'hFF, 1'b0);  // normal now full
    push_req(REQ_APPEND, 8'hA5, 1'b0);  // spills
    push_req(REQ_READ,   8'h00, 1'b0);
    push_req(REQ_APPEND, 8'h5A, 1'b0);  // peak holds data, so peak
    push_req(REQ_APPEND, 8'h3C, 1'b0);
    push_req(REQ_APPEND, 8'h77, 1'b1);  // peak full and still holds data: rejected, chunk fails
    push_req(REQ_APPEND, 8'h01, 1'b1);
    repeat (5) push_req(REQ_READ, 8'h00, 1'b0);
    push_req(REQ_APPEND, 8'h80, 1'b1);  // clean chunk
    push_req(REQ_READ,   8'h00, 1'b1);
    wait_idle();

    // Normal capacity zero
    set_caps(0, 2);
    push_req(REQ_APPEND, 8'h12, 1'b0);
    push_req(REQ_APPEND, 8'h34, 1'b0);
    push_req(REQ_APPEND, 8'h56, 1'b1);
    repeat (2) push_req(REQ_READ, 8'h00, 1'b0);
    wait_idle();

    // Overflow disabled
    set_caps(1, 0);
    push_req(REQ_APPEND, 8'hAB, 1'b0);
    push_req(REQ_APPEND, 8'hCD, 1'b1);
    push_req(REQ_READ,   8'h00, 1'b0);
    wait_idle();

    // Random phases; leftover data meets lowered capacities
    run_phase(4, 6, 150, 60);
    run_phase(0, 8191, 120, 55);
    run_phase(16, 0, 120, 70);
    run_phase(1, 1, 100, 50);
    repeat (3) begin
      run_phase($urandom_range(0, 12), $urandom_range(0, 20), 120,
                $urandom_range(35, 75));
    end
    run_phase(1024, 4096, 100, 50);

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
